/* hw/rtl/utf8_hangul_cyrillic_transliterator_top_assert.svh */
// assertion macros for the transliterator top level
`ifndef UTF8_HANGUL_CYRILLIC_TRANSLITERATOR_TOP_ASSERT_SVH
`define UTF8_HANGUL_CYRILLIC_TRANSLITERATOR_TOP_ASSERT_SVH

// property that must hold on every clock edge outside reset
`define UHCT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property checked also during reset
`define UHCT_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hw/rtl/uhct_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uhct_pkg
// shared types and constants of the hangul to cyrillic transliterator
// ----------------------------------------------------------------------------
package uhct_pkg;

    localparam int unsigned CpW = 21;

    localparam logic [CpW-1:0] HangulFirst = 21'h00AC00;
    localparam logic [CpW-1:0] HangulLast  = 21'h00D7A3;
    localparam logic [CpW-1:0] Replacement = 21'h00FFFD;
    localparam logic [7:0]     NewLine     = 8'h0A;

    // kind of work handed from front to back
    typedef enum logic [1:0] {
        K_NONE   = 2'd0,
        K_PLAIN  = 2'd1,
        K_HANGUL = 2'd2
    } t_kind;

    // one queue entry
    typedef struct packed {
        t_kind          kind;
        logic [CpW-1:0] cp;
        logic [4:0]     li;
        logic [4:0]     vi;
        logic [4:0]     ti;
        logic           eol;
    } t_job;

    typedef enum logic [2:0] {
        S_IDLE  = 3'd0,
        S_INIT  = 3'd1,
        S_VOWEL = 3'd2,
        S_FINAL = 3'd3,
        S_PLAIN = 3'd4,
        S_EOL   = 3'd5
    } t_bstate;

    // cyrillic letters are all in u+0400..u+047f: stored as low 7 bits
    function automatic logic [20:0] initial_letters(input logic [4:0] idx);
        logic [20:0] r;
        r = '0;
        case (idx)
            5'd0:  r = {7'h00, 7'h00, 7'h33};
            5'd1:  r = {7'h00, 7'h3A, 7'h3A};
            5'd2:  r = {7'h00, 7'h00, 7'h3D};
            5'd3:  r = {7'h00, 7'h00, 7'h34};
            5'd4:  r = {7'h00, 7'h42, 7'h42};
            5'd5:  r = {7'h00, 7'h00, 7'h40};
            5'd6:  r = {7'h00, 7'h00, 7'h3C};
            5'd7:  r = {7'h00, 7'h00, 7'h31};
            5'd8:  r = {7'h00, 7'h3F, 7'h3F};
            5'd9:  r = {7'h00, 7'h00, 7'h41};
            5'd10: r = {7'h00, 7'h41, 7'h41};
            5'd11: r = '0;
            5'd12: r = {7'h00, 7'h00, 7'h47};
            5'd13: r = {7'h00, 7'h47, 7'h47};
            5'd14: r = {7'h00, 7'h45, 7'h47};
            5'd15: r = {7'h00, 7'h00, 7'h3A};
            5'd16: r = {7'h00, 7'h00, 7'h42};
            5'd17: r = {7'h00, 7'h00, 7'h3F};
            5'd18: r = {7'h00, 7'h00, 7'h45};
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [20:0] vowel_letters(input logic [4:0] idx);
        logic [20:0] r;
        r = '0;
        case (idx)
            5'd0:  r = {7'h00, 7'h00, 7'h30};
            5'd1:  r = {7'h00, 7'h00, 7'h4D};
            5'd2:  r = {7'h00, 7'h00, 7'h4F};
            5'd3:  r = {7'h00, 7'h00, 7'h35};
            5'd4:  r = {7'h00, 7'h00, 7'h3E};
            5'd5:  r = {7'h00, 7'h00, 7'h4D};
            5'd6:  r = {7'h00, 7'h00, 7'h51};
            5'd7:  r = {7'h00, 7'h00, 7'h35};
            5'd8:  r = {7'h00, 7'h00, 7'h3E};
            5'd9:  r = {7'h00, 7'h30, 7'h32};
            5'd10: r = {7'h00, 7'h4D, 7'h32};
            5'd11: r = {7'h00, 7'h35, 7'h32};
            5'd12: r = {7'h00, 7'h00, 7'h51};
            5'd13: r = {7'h00, 7'h00, 7'h43};
            5'd14: r = {7'h00, 7'h3E, 7'h32};
            5'd15: r = {7'h00, 7'h35, 7'h32};
            5'd16: r = {7'h00, 7'h38, 7'h32};
            5'd17: r = {7'h00, 7'h00, 7'h4E};
            5'd18: r = {7'h00, 7'h00, 7'h4B};
            5'd19: r = {7'h00, 7'h00, 7'h38};
            5'd20: r = {7'h00, 7'h00, 7'h38};
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [20:0] final_letters(input logic [4:0] idx);
        logic [20:0] r;
        r = '0;
        case (idx)
            5'd0:  r = '0;
            5'd1:  r = {7'h00, 7'h00, 7'h3A};
            5'd2:  r = {7'h00, 7'h00, 7'h3A};
            5'd3:  r = {7'h00, 7'h41, 7'h3A};
            5'd4:  r = {7'h00, 7'h00, 7'h3D};
            5'd5:  r = {7'h36, 7'h34, 7'h3D};
            5'd6:  r = {7'h00, 7'h45, 7'h3D};
            5'd7:  r = {7'h00, 7'h00, 7'h42};
            5'd8:  r = {7'h00, 7'h4C, 7'h3B};
            5'd9:  r = {7'h3A, 7'h4C, 7'h3B};
            5'd10: r = {7'h3C, 7'h4C, 7'h3B};
            5'd11: r = {7'h31, 7'h4C, 7'h3B};
            5'd12: r = {7'h41, 7'h4C, 7'h3B};
            5'd13: r = {7'h42, 7'h4C, 7'h3B};
            5'd14: r = {7'h3F, 7'h4C, 7'h3B};
            5'd15: r = {7'h45, 7'h4C, 7'h3B};
            5'd16: r = {7'h00, 7'h00, 7'h3C};
            5'd17: r = {7'h00, 7'h00, 7'h3F};
            5'd18: r = {7'h00, 7'h41, 7'h3F};
            5'd19: r = {7'h00, 7'h00, 7'h42};
            5'd20: r = {7'h00, 7'h00, 7'h42};
            5'd21: r = {7'h00, 7'h00, 7'h3D};
            5'd22: r = {7'h00, 7'h00, 7'h42};
            5'd23: r = {7'h00, 7'h00, 7'h42};
            5'd24: r = {7'h00, 7'h00, 7'h3A};
            5'd25: r = {7'h00, 7'h00, 7'h42};
            5'd26: r = {7'h00, 7'h00, 7'h3F};
            5'd27: r = {7'h00, 7'h00, 7'h42};
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

/* hw/rtl/uhct_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uhct_front
// utf-8 decode and hangul split; produces one job per input byte
// ----------------------------------------------------------------------------
module uhct_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_byte,
    input  logic          i_eol,
    output logic          o_job_valid,
    input  logic          i_job_ready,
    output uhct_pkg::t_job o_job
);

    // stage 0: decoder state, stage 1: offset split, stage 2: hangul indices
    logic [20:0] r_cp, n_cp;
    logic [1:0]  r_rem, n_rem;
    logic        r_brk, n_brk;

    logic        r_v1;
    logic        r_emit1;
    logic [20:0] r_cp1;
    logic        r_eol1;

    logic        w_emit;
    logic [20:0] w_ecp;
    logic        w_take;
    logic        w_adv1;

    // second stage: divide offset by 28 by reciprocal
    logic [13:0] w_s;
    logic [29:0] w_q28p;
    logic [9:0]  w_q28;
    logic [13:0] w_r28;
    logic [9:0]  w_q28c;
    logic [4:0]  w_ti;
    logic        w_hang;

    logic        r_v2;
    uhct_pkg::t_job r_job2;
    logic [9:0]  r_lv;
    logic [9:0]  w_lv;
    logic [21:0] w_q21p;
    logic [4:0]  w_li;
    logic [9:0]  w_r21;
    logic [4:0]  w_li2;
    logic [4:0]  w_vi;

    assign w_adv1 = !r_v2 || i_job_ready;
    assign o_ready = !r_v1 || w_adv1;
    assign w_take = i_valid && o_ready;

    always_comb begin
        n_cp   = r_cp;
        n_rem  = r_rem;
        n_brk  = r_brk;
        w_emit = 1'b0;
        w_ecp  = {13'd0, i_byte};
        if (r_rem == 2'd0) begin
            if (!i_byte[7]) begin
                w_emit = 1'b1;
            end else if (i_byte[7:5] == 3'b110) begin
                n_cp = {16'd0, i_byte[4:0]}; n_rem = 2'd1; n_brk = 1'b0;
            end else if (i_byte[7:4] == 4'b1110) begin
                n_cp = {17'd0, i_byte[3:0]}; n_rem = 2'd2; n_brk = 1'b0;
            end else if (i_byte[7:3] == 5'b11110) begin
                n_cp = {18'd0, i_byte[2:0]}; n_rem = 2'd3; n_brk = 1'b0;
            end
        end else begin
            if (!r_brk) begin
                if (i_byte[7:6] != 2'b10) begin
                    n_cp  = uhct_pkg::Replacement;
                    n_brk = 1'b1;
                end else begin
                    n_cp = {r_cp[14:0], i_byte[5:0]};
                end
            end
            n_rem = r_rem - 2'd1;
            if (n_rem == 2'd0) begin
                w_emit = 1'b1;
                w_ecp  = n_cp;
            end
        end
        if (i_eol && n_rem != 2'd0) begin
            n_rem = 2'd0; n_cp = '0; n_brk = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cp <= '0; r_rem <= '0; r_brk <= 1'b0; r_v1 <= 1'b0; r_v2 <= 1'b0;
        end else begin
            if (w_take) begin
                r_cp <= n_cp; r_rem <= n_rem; r_brk <= n_brk;
            end
            if (o_ready) r_v1 <= i_valid;
            if (w_adv1) r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_emit1 <= w_emit; r_cp1 <= w_ecp; r_eol1 <= i_eol;
        end
    end

    assign w_hang = r_emit1 && r_cp1 >= uhct_pkg::HangulFirst
                    && r_cp1 <= uhct_pkg::HangulLast;
    assign w_s    = 14'(r_cp1 - uhct_pkg::HangulFirst);
    // 37450/2^20 ~ 1/28, exact floor over the syllable range
    assign w_q28p = 30'(w_s) * 30'd37450;
    assign w_q28  = w_q28p[29:20];
    assign w_r28  = w_s - 14'(w_q28) * 14'd28;
    assign w_q28c = (w_r28 >= 14'd28) ? w_q28 + 10'd1 : w_q28;
    assign w_ti   = (w_r28 >= 14'd28) ? 5'(w_r28 - 14'd28) : w_r28[4:0];

    always_ff @(posedge i_clk) begin
        if (w_adv1 && r_v1) begin
            r_job2.kind <= !r_emit1 ? uhct_pkg::K_NONE
                         : (w_hang ? uhct_pkg::K_HANGUL : uhct_pkg::K_PLAIN);
            r_job2.cp   <= r_cp1;
            r_job2.li   <= '0;
            r_job2.vi   <= w_q28c[4:0];
            r_job2.ti   <= w_ti;
            r_job2.eol  <= r_eol1;
            r_lv        <= w_q28c;
        end
    end

    // lv = li*21 + vi, below 399; 3121/65536 ~ 1/21, exact floor here
    assign w_lv   = r_lv;
    assign w_q21p = 22'(w_lv) * 22'd3121;
    assign w_li   = w_q21p[20:16];
    assign w_r21  = w_lv - 10'(w_li) * 10'd21;
    assign w_li2  = (w_r21 >= 10'd21) ? w_li + 5'd1 : w_li;
    assign w_vi   = (w_r21 >= 10'd21) ? 5'(w_r21 - 10'd21) : w_r21[4:0];

    always_comb begin
        o_job    = r_job2;
        o_job.li = w_li2;
        o_job.vi = w_vi;
    end
    assign o_job_valid = r_v2;

endmodule

/* hw/rtl/uhct_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uhct_queue
// two-entry job queue between decoder and encoder
// ----------------------------------------------------------------------------
module uhct_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  uhct_pkg::t_job i_job,
    output logic           o_valid,
    input  logic           i_ready,
    output uhct_pkg::t_job o_job
);

    uhct_pkg::t_job r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_wr, w_rd;

    assign o_ready = r_cnt != 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign w_wr = i_valid && o_ready;
    assign w_rd = o_valid && i_ready;
    assign o_job = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0;
        end else begin
            if (w_wr) r_wp <= ~r_wp;
            if (w_rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_wr} - {1'b0, w_rd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[r_wp] <= i_job;
    end

endmodule

/* hw/rtl/uhct_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uhct_back
// utf-8 encoder sequencer; while the output is not stalled, at most one output byte per cycle
// ----------------------------------------------------------------------------
module uhct_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  uhct_pkg::t_job i_job,
    output logic           o_tvalid,
    input  logic           i_tready,
    output logic [7:0]     o_byte,
    output logic           o_last
);

    uhct_pkg::t_bstate r_st, n_st;
    uhct_pkg::t_job    r_job;
    logic [20:0] r_let;       // letter list of current part
    logic [1:0]  r_li, n_li;  // letter index
    logic [1:0]  r_bi, n_bi;  // byte index within letter or plain code point
    logic        r_ov;
    logic [7:0]  r_ob;
    logic        r_ol;

    logic        w_load, w_step, w_free;
    logic [6:0]  w_cur;
    logic [6:0]  w_next;
    logic [1:0]  w_nb;
    logic [7:0]  w_pb;
    logic [20:0] w_cp;
    logic        w_more;
    logic [20:0] w_vlet, w_flet;
    logic [6:0]  w_f0;
    logic        w_last;

    assign w_free = !r_ov || i_tready;
    assign o_ready = (r_st == uhct_pkg::S_IDLE);
    assign w_load = i_valid && o_ready;
    assign w_step = w_free && r_st != uhct_pkg::S_IDLE;

    assign w_cp = r_job.cp;
    always_comb begin
        w_cur = r_let[7*r_li +: 7];
        w_next = (r_li == 2'd2) ? 7'd0 : r_let[7*(r_li + 2'd1) +: 7];
        w_vlet = uhct_pkg::vowel_letters(r_job.vi);
        w_flet = uhct_pkg::final_letters(r_job.ti);
        w_f0 = w_flet[6:0];
        w_nb = w_cp <= 21'h7F ? 2'd0 : w_cp <= 21'h7FF ? 2'd1
             : w_cp <= 21'hFFFF ? 2'd2 : 2'd3;
        case (r_bi)
            2'd0: w_pb = w_nb == 2'd0 ? {1'b0, w_cp[6:0]}
                       : w_nb == 2'd1 ? {3'b110, w_cp[10:6]}
                       : w_nb == 2'd2 ? {4'b1110, w_cp[15:12]}
                       : {5'b11110, w_cp[20:18]};
            2'd1: w_pb = w_nb == 2'd1 ? {2'b10, w_cp[5:0]}
                       : w_nb == 2'd2 ? {2'b10, w_cp[11:6]} : {2'b10, w_cp[17:12]};
            2'd2: w_pb = w_nb == 2'd2 ? {2'b10, w_cp[5:0]} : {2'b10, w_cp[11:6]};
            default: w_pb = {2'b10, w_cp[5:0]};
        endcase
    end

    // next state
    always_comb begin
        n_st = r_st;
        n_li = r_li;
        n_bi = r_bi;
        w_more = 1'b0;
        case (r_st)
            uhct_pkg::S_IDLE: begin
                n_li = '0; n_bi = '0;
                if (w_load) begin
                    case (i_job.kind)
                        uhct_pkg::K_PLAIN:  n_st = uhct_pkg::S_PLAIN;
                        uhct_pkg::K_HANGUL: n_st = uhct_pkg::S_INIT;
                        default: n_st = i_job.eol ? uhct_pkg::S_EOL : uhct_pkg::S_IDLE;
                    endcase
                end
            end
            uhct_pkg::S_PLAIN: if (w_step) begin
                if (r_bi == w_nb) begin
                    n_st = r_job.eol ? uhct_pkg::S_EOL : uhct_pkg::S_IDLE;
                end else begin
                    n_bi = r_bi + 2'd1;
                end
            end
            uhct_pkg::S_INIT, uhct_pkg::S_VOWEL, uhct_pkg::S_FINAL: if (w_step) begin
                // cyrillic letters take two bytes each
                if (r_st == uhct_pkg::S_INIT && w_cur == 7'd0) begin
                    n_st = uhct_pkg::S_VOWEL; n_li = '0;
                end else if (r_bi == 2'd0) begin
                    n_bi = 2'd1;
                end else begin
                    n_bi = '0;
                    w_more = w_next != 7'd0;
                    if (w_more) begin
                        n_li = r_li + 2'd1;
                    end else begin
                        n_li = '0;
                        case (r_st)
                            uhct_pkg::S_INIT:  n_st = uhct_pkg::S_VOWEL;
                            uhct_pkg::S_VOWEL: n_st = (w_f0 != 7'd0) ? uhct_pkg::S_FINAL
                                : (r_job.eol ? uhct_pkg::S_EOL : uhct_pkg::S_IDLE);
                            default: n_st = r_job.eol ? uhct_pkg::S_EOL : uhct_pkg::S_IDLE;
                        endcase
                    end
                end
            end
            uhct_pkg::S_EOL: if (w_step) n_st = uhct_pkg::S_IDLE;
            default: n_st = uhct_pkg::S_IDLE;
        endcase
    end

    // outputs of the current step
    always_comb begin
        w_last = 1'b0;
        case (r_st)
            uhct_pkg::S_PLAIN: w_last = (r_bi == w_nb) && !r_job.eol;
            uhct_pkg::S_FINAL: w_last = r_bi == 2'd1 && w_next == 7'd0 && !r_job.eol;
            uhct_pkg::S_VOWEL: w_last = r_bi == 2'd1 && w_next == 7'd0 && w_f0 == 7'd0
                                        && !r_job.eol;
            uhct_pkg::S_EOL:   w_last = 1'b1;
            default: w_last = 1'b0;
        endcase
    end

    logic w_emit_step;
    logic [7:0] w_ob;
    always_comb begin
        w_emit_step = 1'b0;
        w_ob = w_pb;
        case (r_st)
            uhct_pkg::S_PLAIN, uhct_pkg::S_EOL: w_emit_step = w_step;
            uhct_pkg::S_INIT, uhct_pkg::S_VOWEL, uhct_pkg::S_FINAL:
                w_emit_step = w_step && !(r_st == uhct_pkg::S_INIT && w_cur == 7'd0);
            default: w_emit_step = 1'b0;
        endcase
        if (r_st == uhct_pkg::S_EOL) begin
            w_ob = uhct_pkg::NewLine;
        end else if (r_st != uhct_pkg::S_PLAIN) begin
            w_ob = r_bi == 2'd0 ? {7'b1101000, w_cur[6]} : {2'b10, w_cur[5:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= uhct_pkg::S_IDLE; r_li <= '0; r_bi <= '0; r_ov <= 1'b0;
        end else begin
            r_st <= n_st; r_li <= n_li; r_bi <= n_bi;
            if (w_emit_step) r_ov <= 1'b1;
            else if (i_tready) r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_job <= i_job;
            r_let <= uhct_pkg::initial_letters(i_job.li);
        end else if (w_step && n_st != r_st) begin
            r_let <= (n_st == uhct_pkg::S_VOWEL) ? w_vlet : w_flet;
        end
        if (w_emit_step) begin
            r_ob <= w_ob; r_ol <= w_last;
        end
    end

    assign o_tvalid = r_ov;
    assign o_byte = r_ob;
    assign o_last = r_ol;

endmodule

/* hw/rtl/utf8_hangul_cyrillic_transliterator_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_hangul_cyrillic_transliterator_top
// utf-8 in, hangul syllables turned into cyrillic letters, utf-8 out
// ----------------------------------------------------------------------------
//  channel  | dir | tdata             | tuser | tlast
//  s_axis   | in  | [7:0] in byte     | -     | line end
//  m_axis   | out | [7:0] out byte    | -     | last byte of this item
//
// each item is first loaded by the encoder sequencer, which then sends the output
// bytes it causes (up to fifteen) one by one; for a syllable with a silent
// initial it also spends a step of its own skipping it
// the decoder takes two register stages and hands jobs through a two-entry queue
// reset is synchronous active low and clears decoder state and all valids
// a stall at the output holds the encoder, then the queue, then the input
`include "utf8_hangul_cyrillic_transliterator_top_assert.svh"
module utf8_hangul_cyrillic_transliterator_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tlast
);

    logic           w_fv, w_fr, w_bv, w_br;
    uhct_pkg::t_job w_fj, w_bj;

    // front: decode and split
    uhct_front u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_byte(s_axis_tdata), .i_eol(s_axis_tlast),
        .o_job_valid(w_fv), .i_job_ready(w_fr), .o_job(w_fj)
    );

    // decoupling queue
    uhct_queue u_queue (
        .i_clk, .i_rst_n,
        .i_valid(w_fv), .o_ready(w_fr), .i_job(w_fj),
        .o_valid(w_bv), .i_ready(w_br), .o_job(w_bj)
    );

    // back: encode bytes
    uhct_back u_back (
        .i_clk, .i_rst_n,
        .i_valid(w_bv), .o_ready(w_br), .i_job(w_bj),
        .o_tvalid(m_axis_tvalid), .i_tready(m_axis_tready),
        .o_byte(m_axis_tdata), .o_last(m_axis_tlast)
    );

    // a held output byte must not change
    `UHCT_ASSERT(a_out_hold, i_clk, i_rst_n,
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata),
        "output byte changed while stalled")
    // a hangul job at the queue head carries an initial index in range
    `UHCT_ASSERT(a_queue_kind, i_clk, i_rst_n,
        w_bv |-> (w_bj.kind != uhct_pkg::K_HANGUL || w_bj.li < 5'd19),
        "hangul initial index out of range")
    // nothing valid right after reset
    `UHCT_ASSERT_ALWAYS(a_reset, i_clk, !i_rst_n |=> !m_axis_tvalid && !w_bv,
        "valid after reset")

endmodule

/* verif/utf8_hangul_cyrillic_transliterator_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_hangul_cyrillic_transliterator_top_tb
// feeds utf-8 bytes and checks every output byte against a local predictor
// of the hangul to cyrillic transliteration
// ----------------------------------------------------------------------------
module utf8_hangul_cyrillic_transliterator_top_tb;

    typedef struct {
        logic [7:0] byte_val;
        logic       last;
    } t_out_byte;

    logic       i_clk;
    logic       i_rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;   // [7:0] in_byte
    logic       s_axis_tlast;   // line end
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;   // [7:0] out_byte
    logic       m_axis_tlast;   // last byte of this item

    t_out_byte  expected_bytes[$];
    int         mismatches = 0;
    int         idle_cycles;
    bit         hold_off;
    bit         done;

    // decoder state of the predictor
    logic [20:0] cp_acc;
    logic [1:0]  cont_left;
    logic        broken;
    t_out_byte   item_bytes[$];

    utf8_hangul_cyrillic_transliterator_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // letter tables, cyrillic code points, zero ends a sequence
    function automatic logic [10:0] lead_letter(input int idx, input int n);
        logic [10:0] t[19][3];
        t = '{'{11'h433, 0, 0}, '{11'h43A, 11'h43A, 0}, '{11'h43D, 0, 0},
              '{11'h434, 0, 0}, '{11'h442, 11'h442, 0}, '{11'h440, 0, 0},
              '{11'h43C, 0, 0}, '{11'h431, 0, 0}, '{11'h43F, 11'h43F, 0},
              '{11'h441, 0, 0}, '{11'h441, 11'h441, 0}, '{0, 0, 0},
              '{11'h447, 0, 0}, '{11'h447, 11'h447, 0}, '{11'h447, 11'h445, 0},
              '{11'h43A, 0, 0}, '{11'h442, 0, 0}, '{11'h43F, 0, 0},
              '{11'h445, 0, 0}};
        return t[idx][n];
    endfunction

    function automatic logic [10:0] vowel_letter(input int idx, input int n);
        logic [10:0] t[21][3];
        t = '{'{11'h430, 0, 0}, '{11'h44D, 0, 0}, '{11'h44F, 0, 0},
              '{11'h435, 0, 0}, '{11'h43E, 0, 0}, '{11'h44D, 0, 0},
              '{11'h451, 0, 0}, '{11'h435, 0, 0}, '{11'h43E, 0, 0},
              '{11'h432, 11'h430, 0}, '{11'h432, 11'h44D, 0},
              '{11'h432, 11'h435, 0}, '{11'h451, 0, 0}, '{11'h443, 0, 0},
              '{11'h432, 11'h43E, 0}, '{11'h432, 11'h435, 0},
              '{11'h432, 11'h438, 0}, '{11'h44E, 0, 0}, '{11'h44B, 0, 0},
              '{11'h438, 0, 0}, '{11'h438, 0, 0}};
        return t[idx][n];
    endfunction

    function automatic logic [10:0] coda_letter(input int idx, input int n);
        logic [10:0] t[28][3];
        t = '{'{0, 0, 0}, '{11'h43A, 0, 0}, '{11'h43A, 0, 0},
              '{11'h43A, 11'h441, 0}, '{11'h43D, 0, 0},
              '{11'h43D, 11'h434, 11'h436}, '{11'h43D, 11'h445, 0},
              '{11'h442, 0, 0}, '{11'h43B, 11'h44C, 0},
              '{11'h43B, 11'h44C, 11'h43A}, '{11'h43B, 11'h44C, 11'h43C},
              '{11'h43B, 11'h44C, 11'h431}, '{11'h43B, 11'h44C, 11'h441},
              '{11'h43B, 11'h44C, 11'h442}, '{11'h43B, 11'h44C, 11'h43F},
              '{11'h43B, 11'h44C, 11'h445}, '{11'h43C, 0, 0},
              '{11'h43F, 0, 0}, '{11'h43F, 11'h441, 0}, '{11'h442, 0, 0},
              '{11'h442, 0, 0}, '{11'h43D, 0, 0}, '{11'h442, 0, 0},
              '{11'h442, 0, 0}, '{11'h43A, 0, 0}, '{11'h442, 0, 0},
              '{11'h43F, 0, 0}, '{11'h442, 0, 0}};
        return t[idx][n];
    endfunction

    task automatic push_byte(input logic [7:0] b);
        t_out_byte o;
        o.byte_val = b;
        o.last     = 1'b0;
        if (item_bytes.size() < 15) item_bytes.insert(item_bytes.size(), o);
    endtask

    task automatic encode_utf8(input logic [20:0] cp);
        if (cp <= 21'h7F) begin
            push_byte(cp[7:0]);
        end else if (cp <= 21'h7FF) begin
            push_byte({3'b110, cp[10:6]});
            push_byte({2'b10, cp[5:0]});
        end else if (cp <= 21'hFFFF) begin
            push_byte({4'b1110, cp[15:12]});
            push_byte({2'b10, cp[11:6]});
            push_byte({2'b10, cp[5:0]});
        end else begin
            push_byte({5'b11110, cp[20:18]});
            push_byte({2'b10, cp[17:12]});
            push_byte({2'b10, cp[11:6]});
            push_byte({2'b10, cp[5:0]});
        end
    endtask

    task automatic emit_code_point(input logic [20:0] cp);
        int s;
        int n;
        if (cp >= uhct_pkg::HangulFirst && cp <= uhct_pkg::HangulLast) begin
            s = int'(cp - uhct_pkg::HangulFirst);
            for (n = 0; n < 3 && lead_letter(s / 588, n) != 0; n++)
                encode_utf8(21'(lead_letter(s / 588, n)));
            for (n = 0; n < 3 && vowel_letter((s % 588) / 28, n) != 0; n++)
                encode_utf8(21'(vowel_letter((s % 588) / 28, n)));
            for (n = 0; n < 3 && coda_letter(s % 28, n) != 0; n++)
                encode_utf8(21'(coda_letter(s % 28, n)));
        end else begin
            encode_utf8(cp);
        end
    endtask

    // works out the output bytes of one accepted input byte
    task automatic transliterate_byte(input logic [7:0] b, input logic eol);
        item_bytes.delete();
        if (cont_left == 0) begin
            if (!b[7]) begin
                emit_code_point(21'(b));
            end else if (b[7:5] == 3'b110) begin
                cp_acc = 21'(b[4:0]); cont_left = 2'd1; broken = 1'b0;
            end else if (b[7:4] == 4'b1110) begin
                cp_acc = 21'(b[3:0]); cont_left = 2'd2; broken = 1'b0;
            end else if (b[7:3] == 5'b11110) begin
                cp_acc = 21'(b[2:0]); cont_left = 2'd3; broken = 1'b0;
            end
        end else begin
            if (!broken) begin
                if (b[7:6] != 2'b10) begin
                    cp_acc = uhct_pkg::Replacement;
                    broken = 1'b1;
                end else begin
                    cp_acc = {cp_acc[14:0], b[5:0]};
                end
            end
            cont_left = cont_left - 2'd1;
            if (cont_left == 0) emit_code_point(cp_acc);
        end
        if (eol) begin
            if (cont_left != 0) begin
                cont_left = 2'd0; cp_acc = '0; broken = 1'b0;
            end
            push_byte(uhct_pkg::NewLine);
        end
        if (item_bytes.size() > 0) item_bytes[item_bytes.size()-1].last = 1'b1;
        foreach (item_bytes[k]) expected_bytes.insert(expected_bytes.size(), item_bytes[k]);
    endtask

    // often no gap, else mostly a short one, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // tvalid stays up after an accept until the next item or a gap
    task automatic send_byte(input logic [7:0] b, input logic eol);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eol;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        transliterate_byte(b, eol);
    endtask

    task automatic send_code_point(input logic [20:0] cp, input logic eol);
        if (cp <= 21'h7F) begin
            send_byte(cp[7:0], eol);
        end else if (cp <= 21'h7FF) begin
            send_byte({3'b110, cp[10:6]}, 1'b0);
            send_byte({2'b10, cp[5:0]}, eol);
        end else if (cp <= 21'hFFFF) begin
            send_byte({4'b1110, cp[15:12]}, 1'b0);
            send_byte({2'b10, cp[11:6]}, 1'b0);
            send_byte({2'b10, cp[5:0]}, eol);
        end else begin
            send_byte({5'b11110, cp[20:18]}, 1'b0);
            send_byte({2'b10, cp[17:12]}, 1'b0);
            send_byte({2'b10, cp[11:6]}, 1'b0);
            send_byte({2'b10, cp[5:0]}, eol);
        end
    endtask

    task automatic test_directed();
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h0A, 1'b0);                     // newline as plain byte
        send_code_point(21'h00AC00, 1'b0);          // first syllable
        send_code_point(21'h00D7A3, 1'b0);          // last syllable
        send_code_point(21'h00AE4D, 1'b0);          // four-letter syllable
        send_code_point(21'h1FFFFF, 1'b0);          // too large, four bytes
        send_code_point(21'h0007FF, 1'b0);
        send_byte(8'h80, 1'b0);                     // stray continuation
        send_byte(8'hFF, 1'b0);                     // invalid lead
        send_byte(8'hF8, 1'b0);
        send_byte(8'hE0, 1'b0);                     // broken sequence
        send_byte(8'h41, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hF0, 1'b0);                     // cut by line end
        send_byte(8'h90, 1'b1);
        send_byte(8'hC0, 1'b0);                     // overlong
        send_byte(8'h80, 1'b1);
        send_byte(8'h20, 1'b1);
    endtask

    task automatic test_random_text();
        int r;
        logic [20:0] cp;
        for (int i = 0; i < 40; i++) begin
            r = $urandom_range(0, 99);
            if (r < 50)
                cp = 21'($urandom_range(32'hAC00, 32'hD7A3));
            else if (r < 62)
                cp = 21'($urandom_range(0, 127));
            else if (r < 72)
                cp = 21'($urandom_range(128, 32'h7FF));
            else if (r < 82)
                cp = 21'($urandom_range(32'h800, 32'hFFFF));
            else
                cp = 21'($urandom_range(32'h10000, 32'h1FFFFF));
            if (r % 9 == 0) begin
                send_byte(8'($urandom), $urandom_range(0, 3) == 0);
            end else begin
                send_code_point(cp, $urandom_range(0, 7) == 0);
            end
        end
    endtask

    // receiver holds off while the sender keeps offering syllables
    task automatic test_back_pressure();
        hold_off = 1'b1;
        for (int i = 0; i < 8; i++)
            send_code_point(21'($urandom_range(32'hAC00, 32'hD7A3)), 1'b0);
        send_byte(8'h2E, 1'b1);
    endtask

    // receiver side: random stalls, or a long hold-off when asked
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_off) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) < 70) ||
                             ($urandom_range(0, 3) == 0);
        end
    end

    initial begin
        hold_off = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                repeat (400) @(posedge i_clk);
                hold_off = 1'b0;
            end
        end
    end

    // compares each output byte with the oldest expected byte
    always @(posedge i_clk) begin
        t_out_byte e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_bytes.size() == 0) begin
                $error("unexpected out_byte %h", m_axis_tdata);
                mismatches++;
            end else begin
                e = expected_bytes.pop_front();
                if (m_axis_tdata !== e.byte_val) begin
                    $error("out_byte expected %h actual %h", e.byte_val, m_axis_tdata);
                    mismatches++;
                end
                if (m_axis_tlast !== e.last) begin
                    $error("run_last expected %b actual %b", e.last, m_axis_tlast);
                    mismatches++;
                end
            end
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready) || done) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles > 3000) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        done = 1'b0;
        cp_acc = '0;
        cont_left = '0;
        broken = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_back_pressure();
        test_random_text();
        s_axis_tvalid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        done = 1'b1;
        if (mismatches == 0 && expected_bytes.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/uhct_pkg.sv
hw/rtl/uhct_front.sv
hw/rtl/uhct_queue.sv
hw/rtl/uhct_back.sv
hw/rtl/utf8_hangul_cyrillic_transliterator_top.sv
verif/utf8_hangul_cyrillic_transliterator_top_tb.sv
